// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- sv/pcs_pkg.sv -----
// Types and constants of the phased countdown sequencer.
package pcs_pkg;

    localparam int unsigned NUM_PHASE_REGS = 4;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_RUNNING  = 2'd1,
        MODE_PAUSED   = 2'd2,
        MODE_FINISHED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EFF_NONE  = 2'd0,
        EFF_STOP  = 2'd1,
        EFF_START = 2'd2
    } effect_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_INVALID_ARG   = 2'd1,
        ST_ILLEGAL_TRANS = 2'd2,
        ST_INVALID_TRANS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        KIND_RESTART = 3'd0,
        KIND_START   = 3'd1,
        KIND_PAUSE   = 3'd2,
        KIND_RESUME  = 3'd3,
        KIND_SKIP    = 3'd4,
        KIND_TIMEOUT = 3'd5
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHASE_COUNT = 3'd0,
        REG_PHASE0_DUR  = 3'd1,
        REG_PHASE1_DUR  = 3'd2,
        REG_PHASE2_DUR  = 3'd3,
        REG_PHASE3_DUR  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                       phase_count;
        logic [NUM_PHASE_REGS-1:0][TIME_W-1:0]    durations;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_now;
        mode_t              machine_state;
        logic [TIME_W-1:0]  timer_ms;
        effect_t            effect;
        status_t            status;
    } result_t;

endpackage

// ----- sv/pcs_cfg_regs.sv -----
// Configuration register file: phase count and per-phase durations.
module pcs_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcs_pkg::TIME_W-1:0]        cfg_data,
    output pcs_pkg::cfg_t                     cfg
);

    pcs_pkg::cfg_t cfg_reg;
    pcs_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (pcs_pkg::cfg_reg_t'(cfg_index))
                pcs_pkg::REG_PHASE_COUNT: cfg_next.phase_count = cfg_data[pcs_pkg::COUNT_W-1:0];
                pcs_pkg::REG_PHASE0_DUR:  cfg_next.durations[0] = cfg_data;
                pcs_pkg::REG_PHASE1_DUR:  cfg_next.durations[1] = cfg_data;
                pcs_pkg::REG_PHASE2_DUR:  cfg_next.durations[2] = cfg_data;
                pcs_pkg::REG_PHASE3_DUR:  cfg_next.durations[3] = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_count <= pcs_pkg::COUNT_W'(1);
            cfg_reg.durations   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/pcs_core.sv -----
// Sequencer state and the combinational event update that produces one result.
`include "assert_macros.svh"
module pcs_core #(
    parameter int unsigned PHASE_LIMIT = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [2:0]                    kind,
    input  logic [pcs_pkg::TIME_W-1:0]    now_ms,
    input  pcs_pkg::cfg_t                 cfg,
    output pcs_pkg::result_t              result
);

    pcs_pkg::mode_t                    mode_reg, mode_next;
    logic [pcs_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [pcs_pkg::TIME_W-1:0]        end_reg, end_next;
    logic [pcs_pkg::TIME_W-1:0]        rem_reg, rem_next;
    pcs_pkg::effect_t                  eff_reg, eff_next;
    logic [pcs_pkg::TIME_W-1:0]        tmo_reg, tmo_next;
    pcs_pkg::status_t                  status;

    logic [pcs_pkg::COUNT_W-1:0]       eff_count;
    logic                              next_ok;
    logic [pcs_pkg::PHASE_W-1:0]       phase_inc;
    logic [pcs_pkg::TIME_W-1:0]        diff;
    logic [pcs_pkg::TIME_W-1:0]        next_dur;

    assign eff_count = (cfg.phase_count > pcs_pkg::COUNT_W'(PHASE_LIMIT)) ?
                       pcs_pkg::COUNT_W'(PHASE_LIMIT) : cfg.phase_count;
    assign next_ok   = ((pcs_pkg::COUNT_W'(phase_reg) + pcs_pkg::COUNT_W'(1)) < eff_count);
    assign phase_inc = phase_reg + pcs_pkg::PHASE_W'(1);
    assign diff      = end_reg - now_ms;
    assign next_dur  = cfg.durations[phase_inc];

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        end_next   = end_reg;
        rem_next   = rem_reg;
        eff_next   = eff_reg;
        tmo_next   = tmo_reg;
        status     = pcs_pkg::ST_OK;
        unique case (pcs_pkg::kind_t'(kind))
            pcs_pkg::KIND_RESTART: begin
                mode_next  = pcs_pkg::MODE_IDLE;
                phase_next = '0;
                end_next   = '0;
                rem_next   = '0;
                eff_next   = pcs_pkg::EFF_STOP;
                tmo_next   = '0;
            end
            pcs_pkg::KIND_START: begin
                eff_next = pcs_pkg::EFF_NONE;
                tmo_next = '0;
                if (mode_reg == pcs_pkg::MODE_IDLE) begin
                    mode_next = pcs_pkg::MODE_RUNNING;
                    end_next  = now_ms + cfg.durations[phase_reg];
                    eff_next  = pcs_pkg::EFF_START;
                    tmo_next  = cfg.durations[phase_reg];
                end else begin
                    status = pcs_pkg::ST_INVALID_TRANS;
                end
            end
            pcs_pkg::KIND_PAUSE: begin
                eff_next = pcs_pkg::EFF_NONE;
                tmo_next = '0;
                if (mode_reg == pcs_pkg::MODE_RUNNING) begin
                    mode_next = pcs_pkg::MODE_PAUSED;
                    rem_next  = ((diff != '0) && !diff[pcs_pkg::TIME_W-1]) ? diff : '0;
                    eff_next  = pcs_pkg::EFF_STOP;
                end else begin
                    status = pcs_pkg::ST_INVALID_TRANS;
                end
            end
            pcs_pkg::KIND_RESUME: begin
                eff_next = pcs_pkg::EFF_NONE;
                tmo_next = '0;
                if (mode_reg == pcs_pkg::MODE_PAUSED) begin
                    mode_next = pcs_pkg::MODE_RUNNING;
                    eff_next  = pcs_pkg::EFF_START;
                    tmo_next  = rem_reg;
                    end_next  = now_ms + rem_reg;
                    rem_next  = '0;
                end else begin
                    status = pcs_pkg::ST_INVALID_TRANS;
                end
            end
            pcs_pkg::KIND_SKIP, pcs_pkg::KIND_TIMEOUT: begin
                eff_next = pcs_pkg::EFF_NONE;
                tmo_next = '0;
                if ((mode_reg == pcs_pkg::MODE_RUNNING) ||
                    (mode_reg == pcs_pkg::MODE_PAUSED && kind == pcs_pkg::KIND_SKIP)) begin
                    if (next_ok) begin
                        mode_next  = pcs_pkg::MODE_RUNNING;
                        phase_next = phase_inc;
                        end_next   = now_ms + next_dur;
                        eff_next   = pcs_pkg::EFF_START;
                        tmo_next   = next_dur;
                    end else begin
                        mode_next = pcs_pkg::MODE_FINISHED;
                        end_next  = '0;
                        rem_next  = '0;
                        eff_next  = pcs_pkg::EFF_STOP;
                    end
                end else if (kind == pcs_pkg::KIND_TIMEOUT &&
                             (mode_reg == pcs_pkg::MODE_PAUSED ||
                              mode_reg == pcs_pkg::MODE_FINISHED)) begin
                    status = pcs_pkg::ST_ILLEGAL_TRANS;
                end else begin
                    status = pcs_pkg::ST_INVALID_TRANS;
                end
            end
            default: begin
                status = pcs_pkg::ST_INVALID_ARG;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= pcs_pkg::MODE_IDLE;
            phase_reg <= '0;
            end_reg   <= '0;
            rem_reg   <= '0;
            eff_reg   <= pcs_pkg::EFF_NONE;
            tmo_reg   <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            end_reg   <= end_next;
            rem_reg   <= rem_next;
            eff_reg   <= eff_next;
            tmo_reg   <= tmo_next;
        end
    end

    assign result.status        = status;
    assign result.effect        = eff_next;
    assign result.timer_ms      = (eff_next == pcs_pkg::EFF_START) ? tmo_next : '0;
    assign result.machine_state = mode_next;
    assign result.phase_now     = phase_next;

    `ASSERT_CLK(a_idle_clean, (mode_reg == pcs_pkg::MODE_IDLE) |-> (phase_reg == '0 && end_reg == '0), "idle with nonzero phase or end time")
    `ASSERT_CLK(a_finished_clean, (mode_reg == pcs_pkg::MODE_FINISHED) |-> (end_reg == '0 && rem_reg == '0), "finished with stale times")
    `ASSERT_CLK(a_hold_when_idle, !step_en |=> $stable(mode_reg) && $stable(phase_reg), "state moved without a word")

endmodule

// ----- sv/phased_countdown_sequencer_top.sv -----
// Top level of the phased countdown sequencer: input register, core and result register.
//
// Usage: event words enter on the s_ stream (s_tuser carries the event kind,
// s_tdata the current millisecond time) and every event word yields exactly one
// result word on the m_ stream. Phase count and phase durations are written on
// the cfg_ channel (index 0 is the count, 1 to 4 the durations); it is always ready.
// The user must write it only while no word is in flight; the block does not enforce it.
// An accepted event word is captured in the input register; when the output register is
// empty or being read, the event is applied to the sequencer state and the result is
// captured in the output register, from which the receiver takes it.
// Throughput is one word per cycle while the receiver does not stall; the state update
// is a single pass of short logic between these two registers.
// When the receiver stalls, the result holds in the output register, one more
// word waits in the input register, and s_tready drops only once both are full.
// Synchronous active-low reset empties both registers, sets the mode to idle at
// phase zero with no effect, and loads a phase count of one with zero durations.
`include "assert_macros.svh"
module phased_countdown_sequencer_top #(
    parameter int unsigned PHASE_SLOTS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // now_ms
    input  logic [2:0]                          s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,   // status, effect, timer_ms,
                                                           // machine_state, phase_now
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int unsigned PHASE_LIMIT =
        (PHASE_SLOTS < pcs_pkg::NUM_PHASE_REGS) ? PHASE_SLOTS : pcs_pkg::NUM_PHASE_REGS;

    logic                          in_valid_reg;
    logic [2:0]                    in_kind_reg;
    logic [pcs_pkg::TIME_W-1:0]    in_now_reg;
    logic                          out_valid_reg;
    pcs_pkg::result_t              out_reg;
    pcs_pkg::result_t              result;
    pcs_pkg::cfg_t                 cfg;
    logic                          advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    pcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcs_core #(
        .PHASE_LIMIT (PHASE_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .kind    (in_kind_reg),
        .now_ms  (in_now_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_now_reg  <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.phase_now, out_reg.machine_state, out_reg.timer_ms,
                       out_reg.effect, out_reg.status};

    `ASSERT_CLK(a_timeout_only_on_start, (m_tvalid && out_reg.effect != pcs_pkg::EFF_START) |-> (out_reg.timer_ms == '0), "timeout without timer start")
    `ASSERT_CLK(a_advance_fills_output, advance |=> m_tvalid, "processed word did not reach the output")
    `ASSERT_NEVER(a_no_drop, in_valid_reg && out_valid_reg && !m_tready && s_tready, "input register overwritten while blocked")

endmodule
